/* rtl/core/hst_pkg.sv */
// ----------------------------------------------------------------------------
// hst_pkg: shared types and codes of the header sync table
// Command and scan mode codes, and the control and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hst_pkg;

	localparam logic [2:0] CMD_ADD          = 3'd0;
	localparam logic [2:0] CMD_GET          = 3'd1;
	localparam logic [2:0] CMD_COUNT_UNLIKE = 3'd2;
	localparam logic [2:0] CMD_COUNT_SYNC   = 3'd3;
	localparam logic [2:0] CMD_CLEAR        = 3'd4;
	localparam logic [2:0] CMD_RESET_INDEX  = 3'd5;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_UNLIKE = 2'd0;
	localparam mode_t MODE_SYNC   = 2'd1;
	localparam mode_t MODE_AFTER  = 2'd2;

	typedef struct packed {
		logic  capture;
		logic  addr_clr;
		logic  scan_rd;
		mode_t scan_mode;
		logic  wr_zero;
		logic  wr_add;
		logic  rd_get;
		logic  hi_zero;
		logic  out_load;
	} ctl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       idx_err;
		logic       scan_last;
		logic       init_last;
		logic       out_free;
	} sts_t;

endpackage

/* rtl/core/header_sync_table.sv */
// Sequence: add, get, reset-index and unused commands go from dispatch straight to
// the response state; count-unlike walks entries 0 to the high-water index once,
// count-after-sync walks them twice and clear zeros them, one entry per cycle
// through the single RAM read port (scans) or the write port (clear).
// Reset: asynchronous; afterwards a clearing pass zeros all TABLE_DEPTH entries of
// the table with s_tready low.
// ----------------------------------------------------------------------------
// header_sync_table: table of remote id, local id and check word per entry
// Command-driven table with merge writes, reads, two match counts, clear and index reset.
// ----------------------------------------------------------------------------
module header_sync_table
	import hst_pkg::*;
#(
	parameter int TABLE_DEPTH = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_index, remote_id, local_id, id_check, start_id, last_synced
	input  logic [175:0] s_tdata,
	// cmd
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_remote, out_local, out_check, match_count, first_remote, last_remote, pad
	output logic [175:0] m_tdata,
	// error
	output logic [0:0]   m_tuser
);

	ctl_t        ctl;
	sts_t        sts;
	logic        error;
	logic [31:0] out_remote;
	logic [31:0] out_local;
	logic [31:0] out_check;
	logic [11:0] match_count;
	logic [31:0] first_remote;
	logic [31:0] last_remote;

	hst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	hst_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (s_tuser),
		.entry_index  (s_tdata[15:0]),
		.remote_id    (s_tdata[47:16]),
		.local_id     (s_tdata[79:48]),
		.id_check     (s_tdata[111:80]),
		.start_id     (s_tdata[143:112]),
		.last_synced  (s_tdata[175:144]),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.error        (error),
		.out_remote   (out_remote),
		.out_local    (out_local),
		.out_check    (out_check),
		.match_count  (match_count),
		.first_remote (first_remote),
		.last_remote  (last_remote)
	);

	assign m_tdata = {4'd0, last_remote, first_remote, match_count,
	                  out_check, out_local, out_remote};
	assign m_tuser = error;

	// One command is in flight at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a command is in flight");

	// A finished result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten");

	// An out-of-range add never reaches the table.
	a_add_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_add |-> !sts.idx_err)
		else $error("out-of-range add written");

	// The RAM ports serve one job per cycle.
	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.wr_zero, ctl.wr_add, ctl.rd_get, ctl.scan_rd}))
		else $error("conflicting table accesses");

endmodule

/* rtl/core/hst_ram.sv */
// ----------------------------------------------------------------------------
// hst_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds while
// no read is enabled.
// ----------------------------------------------------------------------------
module hst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/hst_ctrl.sv */
// ----------------------------------------------------------------------------
// hst_ctrl: command sequencer of the header sync table
// Runs the clearing pass after reset, dispatches each command and steps the
// table scans, then hands the result to the output register.
// ----------------------------------------------------------------------------
module hst_ctrl
	import hst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [3:0] ST_INIT     = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_DISPATCH = 4'd2;
	localparam logic [3:0] ST_SCAN1    = 4'd3;
	localparam logic [3:0] ST_DRAIN1   = 4'd4;
	localparam logic [3:0] ST_SCAN2    = 4'd5;
	localparam logic [3:0] ST_DRAIN2   = 4'd6;
	localparam logic [3:0] ST_CLEAR    = 4'd7;
	localparam logic [3:0] ST_RESP     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				ctl.wr_zero = 1'b1;
				if (sts.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture  = 1'b1;
					ctl.addr_clr = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.cmd)
					CMD_ADD: begin
						ctl.wr_add = !sts.idx_err;
						state_d    = ST_RESP;
					end
					CMD_GET: begin
						ctl.rd_get = !sts.idx_err;
						state_d    = ST_RESP;
					end
					CMD_COUNT_UNLIKE, CMD_COUNT_SYNC: begin
						state_d = ST_SCAN1;
					end
					CMD_CLEAR: begin
						state_d = ST_CLEAR;
					end
					CMD_RESET_INDEX: begin
						ctl.hi_zero = 1'b1;
						state_d     = ST_RESP;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_SCAN1: begin
				ctl.scan_rd   = 1'b1;
				ctl.scan_mode = (sts.cmd == CMD_COUNT_SYNC) ? MODE_SYNC : MODE_UNLIKE;
				if (sts.scan_last) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: begin
				// The last read of the first pass is folded in during this cycle.
				if (sts.cmd == CMD_COUNT_SYNC) begin
					ctl.addr_clr = 1'b1;
					state_d      = ST_SCAN2;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SCAN2: begin
				ctl.scan_rd   = 1'b1;
				ctl.scan_mode = MODE_AFTER;
				if (sts.scan_last) begin
					state_d = ST_DRAIN2;
				end
			end
			ST_DRAIN2: begin
				state_d = ST_RESP;
			end
			ST_CLEAR: begin
				ctl.wr_zero = 1'b1;
				if (sts.scan_last) begin
					ctl.hi_zero = 1'b1;
					state_d     = ST_RESP;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/hst_dpath.sv */
// ----------------------------------------------------------------------------
// hst_dpath: datapath of the header sync table
// Holds the command word, the high-water index, the scan address, the three
// field RAMs, the scan accumulators and the output register.
// ----------------------------------------------------------------------------
module hst_dpath
	import hst_pkg::*;
#(
	parameter int TABLE_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic [2:0]  cmd,
	input  logic [15:0] entry_index,
	input  logic [31:0] remote_id,
	input  logic [31:0] local_id,
	input  logic [31:0] id_check,
	input  logic [31:0] start_id,
	input  logic [31:0] last_synced,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        error,
	output logic [31:0] out_remote,
	output logic [31:0] out_local,
	output logic [31:0] out_check,
	output logic [11:0] match_count,
	output logic [31:0] first_remote,
	output logic [31:0] last_remote
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;

	logic [2:0]    cmd_q;
	logic [15:0]   idx_q;
	logic [31:0]   rid_q;
	logic [31:0]   lid_q;
	logic [31:0]   chk_q;
	logic [31:0]   start_q;
	logic [31:0]   synced_q;

	logic [AW-1:0] hi_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] idx_a;
	logic          idx_err;

	logic          rv_s1;
	mode_t         mode_s1;
	logic [CW-1:0] count_q;
	logic [31:0]   first_q;
	logic [31:0]   sync_q;
	logic [31:0]   count32;

	logic          out_valid_q;

	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          re;
	logic          we_r;
	logic          we_l;
	logic          we_c;
	logic [31:0]   rd_remote;
	logic [31:0]   rd_local;
	logic [31:0]   rd_check;
	logic          get_ok;
	logic          ids_match;

	assign idx_a   = idx_q[AW-1:0];
	assign idx_err = (17'(idx_q) >= 17'(TABLE_DEPTH));
	assign count32 = 32'(count_q);

	assign sts.cmd       = cmd_q;
	assign sts.idx_err   = idx_err;
	assign sts.scan_last = (addr_q == hi_q);
	assign sts.init_last = (addr_q == AW'(TABLE_DEPTH - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= cmd;
			idx_q    <= entry_index;
			rid_q    <= remote_id;
			lid_q    <= local_id;
			chk_q    <= id_check;
			start_q  <= start_id;
			synced_q <= last_synced;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q   <= '0;
			addr_q <= '0;
			rv_s1  <= 1'b0;
		end else begin
			rv_s1 <= ctl.scan_rd;
			if (ctl.hi_zero) begin
				hi_q <= '0;
			end else if (ctl.wr_add && (idx_a > hi_q)) begin
				hi_q <= idx_a;
			end
			if (ctl.addr_clr) begin
				addr_q <= '0;
			end else if (ctl.scan_rd || ctl.wr_zero) begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	// Field RAMs: zero-sweep writes go to the scan address, adds to the entry.
	assign waddr = ctl.wr_add ? idx_a : addr_q;
	assign raddr = ctl.rd_get ? idx_a : addr_q;
	assign re    = ctl.rd_get || ctl.scan_rd;
	assign we_r  = ctl.wr_zero || (ctl.wr_add && (rid_q != '0));
	assign we_l  = ctl.wr_zero || (ctl.wr_add && (lid_q != '0));
	assign we_c  = ctl.wr_zero || (ctl.wr_add && (chk_q != '0));

	hst_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_remote_ram (
		.clk   (clk),
		.we    (we_r),
		.waddr (waddr),
		.wdata (ctl.wr_add ? rid_q : 32'd0),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_remote)
	);

	hst_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_local_ram (
		.clk   (clk),
		.we    (we_l),
		.waddr (waddr),
		.wdata (ctl.wr_add ? lid_q : 32'd0),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_local)
	);

	hst_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_check_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr),
		.wdata (ctl.wr_add ? chk_q : 32'd0),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_check)
	);

	assign ids_match = (rd_remote == rd_local);

	// Scan accumulators see the read data in the cycle after the address.
	always_ff @(posedge clk) begin
		mode_s1 <= ctl.scan_mode;
		if (ctl.capture) begin
			count_q <= '0;
			first_q <= '0;
			sync_q  <= '0;
		end else if (rv_s1) begin
			unique case (mode_s1)
				MODE_UNLIKE: begin
					if (ids_match && (rd_remote != start_q)) begin
						count_q <= count_q + CW'(1);
					end
				end
				MODE_SYNC: begin
					if (rd_remote == synced_q) begin
						sync_q <= rd_local;
					end
				end
				MODE_AFTER: begin
					if (ids_match && (rd_remote > sync_q)) begin
						if (count_q == '0) begin
							first_q <= rd_remote;
						end
						count_q <= count_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign get_ok = (cmd_q == CMD_GET) && !idx_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			error        <= ((cmd_q == CMD_ADD) || (cmd_q == CMD_GET)) && idx_err;
			out_remote   <= get_ok ? rd_remote : 32'd0;
			out_local    <= get_ok ? rd_local : 32'd0;
			out_check    <= get_ok ? rd_check : 32'd0;
			match_count  <= ((cmd_q == CMD_COUNT_UNLIKE) || (cmd_q == CMD_COUNT_SYNC)) ?
			                count32[11:0] : 12'd0;
			first_remote <= (cmd_q == CMD_COUNT_SYNC) ? first_q : 32'd0;
			last_remote  <= (cmd_q == CMD_COUNT_SYNC) ? (first_q + count32 - 32'd1) : 32'd0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the header sync table
// Drives commands on the slave stream in random bursts, predicts every result
// word from a mirror of the table and compares it field by field with the
// words on the master stream, which stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import hst_pkg::*;

	localparam int TABLE_DEPTH = 2048;
	localparam int RANDOM_ITEMS = 114;
	localparam int DRAIN_LIMIT = 20000;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] entry;
		logic [31:0] remote_id;
		logic [31:0] local_id;
		logic [31:0] id_check;
		logic [31:0] start_id;
		logic [31:0] last_synced;
	} table_cmd_t;

	typedef struct packed {
		logic        error;
		logic [31:0] out_remote;
		logic [31:0] out_local;
		logic [31:0] out_check;
		logic [11:0] match_count;
		logic [31:0] first_remote;
		logic [31:0] last_remote;
	} table_word_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [175:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [175:0] m_tdata;
	logic [0:0]   m_tuser;

	// Mirror of the table as the block should hold it.
	logic [31:0] remote_mirror [TABLE_DEPTH];
	logic [31:0] local_mirror [TABLE_DEPTH];
	logic [31:0] check_mirror [TABLE_DEPTH];
	logic [10:0] high_water = '0;

	table_word_t pending_words [$];
	logic [31:0] id_pool [8];
	int          cmd_tally [8];
	int          fail_count = 0;
	int          words_checked = 0;
	int          burst_left = 0;
	int          stall_cycle = 0;

	header_sync_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic predict_table_word(input table_cmd_t c, output table_word_t w);
		int unsigned n;
		logic [31:0] synced_local;
		logic [31:0] first_id;
		w = '0;
		n = 0;
		synced_local = '0;
		first_id = '0;
		case (c.op)
		CMD_ADD: begin
			if (c.entry >= TABLE_DEPTH) begin
				w.error = 1'b1;
			end else begin
				if (c.entry > high_water) high_water = c.entry[10:0];
				if (c.remote_id != '0) remote_mirror[c.entry] = c.remote_id;
				if (c.local_id != '0) local_mirror[c.entry] = c.local_id;
				if (c.id_check != '0) check_mirror[c.entry] = c.id_check;
			end
		end
		CMD_GET: begin
			if (c.entry >= TABLE_DEPTH) begin
				w.error = 1'b1;
			end else begin
				w.out_remote = remote_mirror[c.entry];
				w.out_local = local_mirror[c.entry];
				w.out_check = check_mirror[c.entry];
			end
		end
		CMD_COUNT_UNLIKE: begin
			for (int i = 0; i <= high_water; i++)
				if (remote_mirror[i] == local_mirror[i] && remote_mirror[i] != c.start_id)
					n++;
			w.match_count = n[11:0];
		end
		CMD_COUNT_SYNC: begin
			// The last entry whose remote id matches wins.
			for (int i = 0; i <= high_water; i++)
				if (remote_mirror[i] == c.last_synced) synced_local = local_mirror[i];
			for (int i = 0; i <= high_water; i++) begin
				if (remote_mirror[i] == local_mirror[i] && remote_mirror[i] > synced_local) begin
					if (n == 0) first_id = remote_mirror[i];
					n++;
				end
			end
			w.match_count = n[11:0];
			w.first_remote = first_id;
			w.last_remote = first_id + n - 32'd1;
		end
		CMD_CLEAR: begin
			for (int i = 0; i <= high_water; i++) begin
				remote_mirror[i] = '0;
				local_mirror[i] = '0;
				check_mirror[i] = '0;
			end
			high_water = '0;
		end
		CMD_RESET_INDEX: begin
			high_water = '0;
		end
		default: begin
		end
		endcase
	endtask

	function automatic table_cmd_t make_cmd(logic [2:0] op, logic [15:0] entry,
			logic [31:0] remote_id, logic [31:0] local_id, logic [31:0] id_check,
			logic [31:0] start_id, logic [31:0] last_synced);
		table_cmd_t c;
		c.op = op;
		c.entry = entry;
		c.remote_id = remote_id;
		c.local_id = local_id;
		c.id_check = id_check;
		c.start_id = start_id;
		c.last_synced = last_synced;
		return c;
	endfunction

	// Presents one command word, waits for it to be taken and records the
	// word it must produce. Ends a burst with a gap of random length.
	task automatic send_cmd(input table_cmd_t c);
		table_word_t w;
		@(negedge clk);
		s_tuser = c.op;
		s_tdata = {c.last_synced, c.start_id, c.id_check, c.local_id, c.remote_id, c.entry};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_table_word(c, w);
		pending_words.push_back(w);
		cmd_tally[c.op]++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endfunction

	// Sender idles between bursts; the receiver rotates through its own four
	// stall patterns.
	always @(negedge clk) begin
		case ((stall_cycle / 113) % 4)
		0: m_tready = 1'b1;
		1: m_tready = 1'($urandom_range(0, 1));
		2: m_tready = (stall_cycle % 3 == 0);
		default: m_tready = (stall_cycle % 7) > 4;
		endcase
		stall_cycle++;
	end

	always @(posedge clk) begin : word_check
		table_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$error("result word with no command outstanding: %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				compare_field("error", 32'(want.error), 32'(m_tuser[0]));
				compare_field("out_remote", want.out_remote, m_tdata[31:0]);
				compare_field("out_local", want.out_local, m_tdata[63:32]);
				compare_field("out_check", want.out_check, m_tdata[95:64]);
				compare_field("match_count", 32'(want.match_count), 32'(m_tdata[107:96]));
				compare_field("first_remote", want.first_remote, m_tdata[139:108]);
				compare_field("last_remote", want.last_remote, m_tdata[171:140]);
			end
		end
	end

	task automatic test_power_up();
		send_cmd(make_cmd(CMD_GET, 16'd0, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(CMD_COUNT_UNLIKE, 16'd0, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(CMD_COUNT_SYNC, 16'd0, '0, '0, '0, '0, '0));
	endtask

	task automatic test_merge_writes();
		send_cmd(make_cmd(CMD_ADD, 16'd0, '1, '1, '1, '0, '0));
		send_cmd(make_cmd(CMD_ADD, 16'd0, 32'h1234_5678, '0, '0, '1, '1));
		send_cmd(make_cmd(CMD_GET, 16'd0, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(CMD_ADD, 16'(TABLE_DEPTH - 1), 32'h8000_0001, 32'h8000_0001, '1,
			'0, '0));
		send_cmd(make_cmd(CMD_GET, 16'(TABLE_DEPTH - 1), '1, '1, '1, '1, '1));
	endtask

	task automatic test_range_errors();
		send_cmd(make_cmd(CMD_ADD, 16'(TABLE_DEPTH), 32'h5, 32'h5, 32'h5, '0, '0));
		send_cmd(make_cmd(CMD_ADD, 16'hFFFF, '1, '1, '1, '0, '0));
		send_cmd(make_cmd(CMD_GET, 16'(TABLE_DEPTH), '0, '0, '0, '0, '0));
		// Full-depth scan while the high-water index sits at the top entry.
		send_cmd(make_cmd(CMD_COUNT_UNLIKE, 16'd0, '0, '0, '0, '0, '0));
	endtask

	task automatic test_counts();
		send_cmd(make_cmd(CMD_CLEAR, 16'd0, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(CMD_ADD, 16'd1, 32'd10, 32'd10, 32'hA5A5_A5A5, '0, '0));
		send_cmd(make_cmd(CMD_ADD, 16'd2, 32'd20, 32'd20, '0, '0, '0));
		send_cmd(make_cmd(CMD_ADD, 16'd3, 32'd20, 32'd25, 32'h1, '0, '0));
		send_cmd(make_cmd(CMD_COUNT_UNLIKE, 16'd0, '0, '0, '0, 32'd20, '0));
		// Synced partner id 25 leaves nothing above it to count.
		send_cmd(make_cmd(CMD_COUNT_SYNC, 16'd0, '0, '0, '0, '0, 32'd20));
		send_cmd(make_cmd(CMD_COUNT_SYNC, 16'd0, '0, '0, '0, '0, 32'd10));
	endtask

	task automatic test_index_and_clear();
		send_cmd(make_cmd(CMD_RESET_INDEX, 16'd0, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(CMD_GET, 16'd3, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(CMD_COUNT_UNLIKE, 16'd0, '0, '0, '0, 32'd7, '0));
		// Only entry 0 lies in range now, so entry 3 must survive the clear.
		send_cmd(make_cmd(CMD_CLEAR, 16'd0, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(CMD_GET, 16'd3, '0, '0, '0, '0, '0));
	endtask

	task automatic test_spare_codes();
		send_cmd(make_cmd(CMD_SPARE_LO, 16'd1, '1, '1, '1, '1, '1));
		send_cmd(make_cmd(CMD_SPARE_HI, 16'hFFFF, '1, '1, '1, '1, '1));
	endtask

	function automatic logic [15:0] pick_entry();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85) return 16'($urandom_range(0, 31));
		if (roll < 97) return 16'($urandom_range(TABLE_DEPTH, 65535));
		return 16'(TABLE_DEPTH - 1);
	endfunction

	task automatic test_random_traffic();
		table_cmd_t c;
		int roll;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Fresh id pool every few dozen commands so that matches keep coming.
			if (n % 35 == 0)
				for (int k = 0; k < 8; k++)
					id_pool[k] = (k == 0) ? 32'h1 : (k == 1) ? '1 : $urandom;
			c = make_cmd(3'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
				$urandom, $urandom);
			roll = $urandom_range(0, 99);
			if (roll < 42) begin
				c.op = CMD_ADD;
				c.entry = pick_entry();
				case ($urandom_range(0, 5))
				0, 1, 2: begin
					c.remote_id = id_pool[$urandom_range(0, 7)];
					c.local_id = c.remote_id;
				end
				3: begin
					c.remote_id = id_pool[$urandom_range(0, 7)];
					c.local_id = id_pool[$urandom_range(0, 7)];
				end
				4: c.remote_id = '0;
				default: c.local_id = '0;
				endcase
				if ($urandom_range(0, 2) == 0) c.id_check = '0;
			end else if (roll < 62) begin
				c.op = CMD_GET;
				c.entry = pick_entry();
			end else if (roll < 75) begin
				c.op = CMD_COUNT_UNLIKE;
				if ($urandom_range(0, 3) != 0) c.start_id = id_pool[$urandom_range(0, 7)];
			end else if (roll < 88) begin
				c.op = CMD_COUNT_SYNC;
				case ($urandom_range(0, 2))
				0: c.last_synced = remote_mirror[$urandom_range(0, 31)];
				1: c.last_synced = id_pool[$urandom_range(0, 7)];
				default: begin
				end
				endcase
			end else if (roll < 93) begin
				c.op = CMD_CLEAR;
			end else if (roll < 97) begin
				c.op = CMD_RESET_INDEX;
			end else begin
				c.op = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
			end
			send_cmd(c);
		end
	endtask

	initial begin : main
		int guard;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			remote_mirror[i] = '0;
			local_mirror[i] = '0;
			check_mirror[i] = '0;
		end
		for (int k = 0; k < 8; k++) cmd_tally[k] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_power_up();
		test_merge_writes();
		test_range_errors();
		test_counts();
		test_index_and_clear();
		test_spare_codes();
		test_random_traffic();

		@(negedge clk);
		s_tvalid = 1'b0;
		guard = 0;
		while (pending_words.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (pending_words.size() != 0) begin
			$error("timed out with %0d result words outstanding", pending_words.size());
			fail_count++;
		end
		repeat (10) @(posedge clk);

		$display("Run covered %0d result words: %0d adds, %0d gets, %0d unlike counts,",
			words_checked, cmd_tally[CMD_ADD], cmd_tally[CMD_GET],
			cmd_tally[CMD_COUNT_UNLIKE]);
		$display("%0d sync counts, %0d clears, %0d index resets, %0d spare codes.",
			cmd_tally[CMD_COUNT_SYNC], cmd_tally[CMD_CLEAR], cmd_tally[CMD_RESET_INDEX],
			cmd_tally[CMD_SPARE_LO] + cmd_tally[CMD_SPARE_HI]);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
